// ===== hdl/mmc_pkg.sv =====
// Shared constants, types and fixed-point helpers for the converter Euler step.
// Used by the phase lane, the top level and the testbench.
package mmc_pkg;

   localparam int CELLS_PER_ARM   = 6;
   localparam int CELLS_PER_PHASE = 2 * CELLS_PER_ARM;
   localparam int CNT_W           = $clog2(CELLS_PER_PHASE);
   localparam int SUM_W           = 32 + $clog2(CELLS_PER_ARM) + 1;

   typedef logic [CELLS_PER_PHASE-1:0] mask_type;

   // register indexes of the configuration port
   localparam logic [2:0] REG_CAP_STEP_GAIN = 3'd0;
   localparam logic [2:0] REG_IND_STEP_GAIN = 3'd1;
   localparam logic [2:0] REG_ARM_RES       = 3'd2;
   localparam logic [2:0] REG_LEAK_FACTOR   = 3'd3;
   localparam logic [2:0] REG_INIT_VOLT     = 3'd4;

   // lane operations
   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_LOAD = 4'd1;
   localparam logic [3:0] OP_CAPU = 4'd2;
   localparam logic [3:0] OP_CAPL = 4'd3;
   localparam logic [3:0] OP_RESU = 4'd4;
   localparam logic [3:0] OP_RESL = 4'd5;
   localparam logic [3:0] OP_CELL = 4'd6;
   localparam logic [3:0] OP_DRV  = 4'd7;
   localparam logic [3:0] OP_MULU = 4'd8;
   localparam logic [3:0] OP_MULL = 4'd9;
   localparam logic [3:0] OP_OUT  = 4'd10;

   typedef struct packed {
      logic [3:0] op;
      logic       lower;
      logic       reload;
   } lane_ctrl_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      logic [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // round to nearest, ties up, then saturate
   function automatic logic [31:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] x;
      x = p + 64'sd536870912;
      return sat32(x >>> 30);
   endfunction

   function automatic logic [31:0] round_q16(input logic signed [63:0] p);
      logic signed [63:0] x;
      x = p + 64'sd32768;
      return sat32(x >>> 16);
   endfunction

endpackage

// ===== hdl/mmc_req_if.sv =====
// Input channel of the converter Euler step: one time step per transaction.
// Depends on nothing.
interface mmc_req_if;
   logic               valid;
   logic               ready;
   logic [11:0]        switch_a;
   logic [11:0]        switch_b;
   logic [11:0]        switch_c;
   logic signed [31:0] dc_upper_volt;
   logic signed [31:0] dc_lower_volt;
   logic signed [31:0] out_volt_a;
   logic signed [31:0] out_volt_b;
   logic signed [31:0] out_volt_c;
   logic               reload;

   modport source (output valid, switch_a, switch_b, switch_c, dc_upper_volt,
                   dc_lower_volt, out_volt_a, out_volt_b, out_volt_c, reload,
                   input ready);
   modport sink (input valid, switch_a, switch_b, switch_c, dc_upper_volt,
                 dc_lower_volt, out_volt_a, out_volt_b, out_volt_c, reload,
                 output ready);
endinterface

// ===== hdl/mmc_rsp_if.sv =====
// Result channel of the converter Euler step: one cell index per transaction.
// Depends on nothing.
interface mmc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] cap_volt_a;
   logic signed [31:0] cap_volt_b;
   logic signed [31:0] cap_volt_c;
   logic signed [31:0] cur_up_a;
   logic signed [31:0] cur_low_a;
   logic signed [31:0] cur_up_b;
   logic signed [31:0] cur_low_b;
   logic signed [31:0] cur_up_c;
   logic signed [31:0] cur_low_c;
   logic signed [31:0] dc_pos_current;
   logic signed [31:0] dc_neg_current;
   logic               last_cell;

   modport source (output valid, cap_volt_a, cap_volt_b, cap_volt_c, cur_up_a,
                   cur_low_a, cur_up_b, cur_low_b, cur_up_c, cur_low_c,
                   dc_pos_current, dc_neg_current, last_cell, input ready);
   modport sink (input valid, cap_volt_a, cap_volt_b, cap_volt_c, cur_up_a,
                 cur_low_a, cur_up_b, cur_low_b, cur_up_c, cur_low_c,
                 dc_pos_current, dc_neg_current, last_cell, output ready);
endinterface

// ===== hdl/mmc_cell.sv =====
// One capacitor cell of the rotating chain: holds one voltage, Q16.16.
// Depends on nothing.
module mmc_cell (
   input  logic        clock,
   input  logic        reset,
   input  logic        load_en,
   input  logic [31:0] load_val,
   input  logic        shift_en,
   input  logic [31:0] shift_val,
   output logic [31:0] value
);

   logic [31:0] value_ff;
   logic [31:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (load_en) begin
         value_in = load_val;
      end else if (shift_en) begin
         value_in = shift_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== hdl/mmc_lane.sv =====
// One phase: a chain of cells rotating past a shared update unit, plus the
// two arm currents. Depends on mmc_pkg and mmc_cell.
module mmc_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  mmc_pkg::lane_ctrl_type ctrl,
   input  mmc_pkg::mask_type      mask_in,
   input  logic [31:0]            init_val,
   input  logic [30:0]            cap_gain,
   input  logic [30:0]            ind_gain,
   input  logic [30:0]            res_gain,
   input  logic [30:0]            leak_gain,
   input  logic [31:0]            vsrc_up,
   input  logic [31:0]            vsrc_low,
   input  logic [31:0]            vout,
   output logic [31:0]            head,
   output logic [31:0]            cur_up,
   output logic [31:0]            cur_low
);

   localparam int NC = mmc_pkg::CELLS_PER_PHASE;
   localparam int NA = mmc_pkg::CELLS_PER_ARM;
   localparam int SW = mmc_pkg::SUM_W;

   logic [31:0]       cell_val [NC];
   logic [31:0]       tail_val;
   logic [31:0]       neg_init;
   logic              load_en;
   logic              shift_en;

   mmc_pkg::mask_type mask_ff, mask_in_nx;
   logic [31:0]       cur_up_ff, cur_up_in;
   logic [31:0]       cur_low_ff, cur_low_in;
   logic [31:0]       capp_up_ff, capp_up_in;
   logic [31:0]       capp_low_ff, capp_low_in;
   logic [31:0]       resp_up_ff, resp_up_in;
   logic [31:0]       resp_low_ff, resp_low_in;
   logic [31:0]       drv_up_ff, drv_up_in;
   logic [31:0]       drv_low_ff, drv_low_in;
   logic [SW-1:0]     sum_up_ff, sum_up_in;
   logic [SW-1:0]     sum_low_ff, sum_low_in;

   logic [31:0]        mul_a;
   logic [30:0]        mul_g;
   logic signed [63:0] prod;
   logic [31:0]        r30;
   logic [31:0]        r16;
   logic [31:0]        cap_add;
   logic [31:0]        new_val;

   assign neg_init = mmc_pkg::sat32(-{{32{init_val[31]}}, init_val});
   assign load_en  = (ctrl.op == mmc_pkg::OP_LOAD) && ctrl.reload;
   assign shift_en = (ctrl.op == mmc_pkg::OP_CELL) || (ctrl.op == mmc_pkg::OP_OUT);

   genvar j;
   generate
      for (j = 0; j < NC; j++) begin : g_chain
         logic [31:0] nxt;
         if (j == NC - 1) begin : g_tail
            assign nxt = tail_val;
         end else begin : g_mid
            assign nxt = cell_val[j+1];
         end
         mmc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .load_en   (load_en),
            .load_val  ((j < NA) ? init_val : neg_init),
            .shift_en  (shift_en),
            .shift_val (nxt),
            .value     (cell_val[j])
         );
      end
   endgenerate

   assign head = cell_val[0];

   // shared multiplier operand selection
   always_comb begin
      mul_a = cell_val[0];
      mul_g = leak_gain;
      case (ctrl.op)
         mmc_pkg::OP_CAPU: begin mul_a = cur_up_ff;  mul_g = cap_gain; end
         mmc_pkg::OP_CAPL: begin mul_a = cur_low_ff; mul_g = cap_gain; end
         mmc_pkg::OP_RESU: begin mul_a = cur_up_ff;  mul_g = res_gain; end
         mmc_pkg::OP_RESL: begin mul_a = cur_low_ff; mul_g = res_gain; end
         mmc_pkg::OP_MULU: begin mul_a = drv_up_ff;  mul_g = ind_gain; end
         mmc_pkg::OP_MULL: begin mul_a = drv_low_ff; mul_g = ind_gain; end
         default: begin end
      endcase
   end

   assign prod = $signed({{32{mul_a[31]}}, mul_a}) * $signed({33'b0, mul_g});
   assign r30  = mmc_pkg::round_q30(prod);
   assign r16  = mmc_pkg::round_q16(prod);

   assign cap_add = mmc_pkg::sat32({{32{cell_val[0][31]}}, cell_val[0]} +
                    (ctrl.lower ? {{32{capp_low_ff[31]}}, capp_low_ff}
                                : {{32{capp_up_ff[31]}}, capp_up_ff}));
   assign new_val = mask_ff[0] ? cap_add : r30;
   assign tail_val = (ctrl.op == mmc_pkg::OP_CELL) ? new_val : cell_val[0];

   always_comb begin
      mask_in_nx  = mask_ff;
      cur_up_in   = cur_up_ff;
      cur_low_in  = cur_low_ff;
      capp_up_in  = capp_up_ff;
      capp_low_in = capp_low_ff;
      resp_up_in  = resp_up_ff;
      resp_low_in = resp_low_ff;
      drv_up_in   = drv_up_ff;
      drv_low_in  = drv_low_ff;
      sum_up_in   = sum_up_ff;
      sum_low_in  = sum_low_ff;
      case (ctrl.op)
         mmc_pkg::OP_LOAD: begin
            mask_in_nx = mask_in;
            sum_up_in  = '0;
            sum_low_in = '0;
            if (ctrl.reload) begin
               cur_up_in  = '0;
               cur_low_in = '0;
            end
         end
         mmc_pkg::OP_CAPU: capp_up_in  = r30;
         mmc_pkg::OP_CAPL: capp_low_in = r30;
         mmc_pkg::OP_RESU: resp_up_in  = r16;
         mmc_pkg::OP_RESL: resp_low_in = r16;
         mmc_pkg::OP_CELL: begin
            // advance the mask with the chain so bit 0 follows the head cell
            mask_in_nx = {mask_ff[0], mask_ff[NC-1:1]};
            if (mask_ff[0]) begin
               if (ctrl.lower) begin
                  sum_low_in = sum_low_ff + {{(SW-32){new_val[31]}}, new_val};
               end else begin
                  sum_up_in = sum_up_ff + {{(SW-32){new_val[31]}}, new_val};
               end
            end
         end
         mmc_pkg::OP_DRV: begin
            drv_up_in = mmc_pkg::sat32({{32{vsrc_up[31]}}, vsrc_up}
               - 64'($signed(mmc_pkg::sat32(64'($signed(sum_up_ff)))))
               - 64'($signed(resp_up_ff)) - 64'($signed(vout)));
            drv_low_in = mmc_pkg::sat32({{32{vsrc_low[31]}}, vsrc_low}
               - 64'($signed(mmc_pkg::sat32(64'($signed(sum_low_ff)))))
               - 64'($signed(resp_low_ff)) - 64'($signed(vout)));
         end
         mmc_pkg::OP_MULU: cur_up_in = mmc_pkg::sat32(64'($signed(cur_up_ff))
                                                      + 64'($signed(r30)));
         mmc_pkg::OP_MULL: cur_low_in = mmc_pkg::sat32(64'($signed(cur_low_ff))
                                                       + 64'($signed(r30)));
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_up_ff  <= '0;
         cur_low_ff <= '0;
      end else begin
         cur_up_ff  <= cur_up_in;
         cur_low_ff <= cur_low_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in_nx;
      capp_up_ff  <= capp_up_in;
      capp_low_ff <= capp_low_in;
      resp_up_ff  <= resp_up_in;
      resp_low_ff <= resp_low_in;
      drv_up_ff   <= drv_up_in;
      drv_low_ff  <= drv_low_in;
      sum_up_ff   <= sum_up_in;
      sum_low_ff  <= sum_low_in;
   end

   assign cur_up  = cur_up_ff;
   assign cur_low = cur_low_ff;

endmodule

// ===== hdl/mmc_converter_euler_step.sv =====
// Averaged modular multilevel converter, one forward Euler step per request.
// Channels: req_chan takes one time step (switch masks, source and output
// voltages, reload flag); rsp_chan returns twelve transactions per step, one
// per cell index, each carrying that index's three cell voltages, the six new
// arm currents and the two DC-side sums; last_cell marks the twelfth.
// csr_* writes the five configuration registers; write only while idle.
// Sequence: after a request is accepted the block loads the masks, forms the
// capacitor and resistor gain products of both arms, updates the twelve
// cells in turn, forms the arm drives and the two new arm currents, and sums
// the DC-side currents; the twelve results then leave at one per cycle while
// the receiver takes them. The steps run in turn because the single multiplier
// in each phase lane serves every cell update and every current product.
// Reset: registers return to their reset values, all cell voltages and arm
// currents clear to zero, and the block is idle and ready.
// Stall: a held result keeps its value and the cell chain stays still until
// the result is taken; no new request is taken until all twelve have left.
module mmc_converter_euler_step (
   input  logic        clock,
   input  logic        reset,
   mmc_req_if.sink     req_chan,
   mmc_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int NC = mmc_pkg::CELLS_PER_PHASE;
   localparam int CW = mmc_pkg::CNT_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LOAD  = 4'd1;
   localparam logic [3:0] ST_CAPU  = 4'd2;
   localparam logic [3:0] ST_CAPL  = 4'd3;
   localparam logic [3:0] ST_RESU  = 4'd4;
   localparam logic [3:0] ST_RESL  = 4'd5;
   localparam logic [3:0] ST_CELL  = 4'd6;
   localparam logic [3:0] ST_DRV   = 4'd7;
   localparam logic [3:0] ST_MULU  = 4'd8;
   localparam logic [3:0] ST_MULL  = 4'd9;
   localparam logic [3:0] ST_DCSUM = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   localparam logic [CW-1:0] LAST_IDX = CW'(NC - 1);
   localparam logic [CW-1:0] ARM_IDX  = CW'(mmc_pkg::CELLS_PER_ARM);

   logic [30:0] cap_gain_ff, ind_gain_ff, res_gain_ff, leak_ff;
   logic [31:0] init_ff;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   mmc_pkg::mask_type mask_a_ff, mask_b_ff, mask_c_ff;
   logic [31:0] vsrc_up_ff, vsrc_low_ff;
   logic [31:0] vout_a_ff, vout_b_ff, vout_c_ff;
   logic        reload_ff;
   logic [31:0] dc_pos_ff, dc_pos_in, dc_neg_ff, dc_neg_in;

   logic        req_take;
   logic        rsp_take;
   mmc_pkg::lane_ctrl_type ctrl;

   logic [31:0] head_a, head_b, head_c;
   logic [31:0] up_a, low_a, up_b, low_b, up_c, low_c;

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_gain_ff <= '0;
         ind_gain_ff <= '0;
         res_gain_ff <= 31'd6554;
         leak_ff     <= 31'd1073741824;
         init_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            mmc_pkg::REG_CAP_STEP_GAIN: cap_gain_ff <= csr_wdata[30:0];
            mmc_pkg::REG_IND_STEP_GAIN: ind_gain_ff <= csr_wdata[30:0];
            mmc_pkg::REG_ARM_RES:       res_gain_ff <= csr_wdata[30:0];
            mmc_pkg::REG_LEAK_FACTOR:   leak_ff     <= csr_wdata[30:0];
            mmc_pkg::REG_INIT_VOLT:     init_ff     <= csr_wdata;
            default: begin end
         endcase
      end
   end

   // hold the transaction's fields for the whole step
   always_ff @(posedge clock) begin
      if (req_take) begin
         mask_a_ff   <= mmc_pkg::mask_type'(req_chan.switch_a);
         mask_b_ff   <= mmc_pkg::mask_type'(req_chan.switch_b);
         mask_c_ff   <= mmc_pkg::mask_type'(req_chan.switch_c);
         vsrc_up_ff  <= req_chan.dc_upper_volt;
         vsrc_low_ff <= req_chan.dc_lower_volt;
         vout_a_ff   <= req_chan.out_volt_a;
         vout_b_ff   <= req_chan.out_volt_b;
         vout_c_ff   <= req_chan.out_volt_c;
         reload_ff   <= req_chan.reload;
      end
      dc_pos_ff <= dc_pos_in;
      dc_neg_ff <= dc_neg_in;
   end

   always_comb begin
      dc_pos_in = dc_pos_ff;
      dc_neg_in = dc_neg_ff;
      if (state_ff == ST_DCSUM) begin
         dc_pos_in = mmc_pkg::sat32(64'($signed(up_a)) + 64'($signed(up_b))
                                    + 64'($signed(up_c)));
         dc_neg_in = mmc_pkg::sat32(-(64'($signed(low_a)) + 64'($signed(low_b))
                                    + 64'($signed(low_c))));
      end
   end

   // step sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_CAPU;
         ST_CAPU:  state_in = ST_CAPL;
         ST_CAPL:  state_in = ST_RESU;
         ST_RESU:  state_in = ST_RESL;
         ST_RESL: begin
            state_in = ST_CELL;
            cnt_in   = '0;
         end
         ST_CELL: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRV;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRV:   state_in = ST_MULU;
         ST_MULU:  state_in = ST_MULL;
         ST_MULL:  state_in = ST_DCSUM;
         ST_DCSUM: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_take) begin
               if (cnt_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      ctrl.lower  = (cnt_ff >= ARM_IDX);
      ctrl.reload = reload_ff;
      unique case (state_ff)
         ST_LOAD: ctrl.op = mmc_pkg::OP_LOAD;
         ST_CAPU: ctrl.op = mmc_pkg::OP_CAPU;
         ST_CAPL: ctrl.op = mmc_pkg::OP_CAPL;
         ST_RESU: ctrl.op = mmc_pkg::OP_RESU;
         ST_RESL: ctrl.op = mmc_pkg::OP_RESL;
         ST_CELL: ctrl.op = mmc_pkg::OP_CELL;
         ST_DRV:  ctrl.op = mmc_pkg::OP_DRV;
         ST_MULU: ctrl.op = mmc_pkg::OP_MULU;
         ST_MULL: ctrl.op = mmc_pkg::OP_MULL;
         ST_OUT:  ctrl.op = rsp_take ? mmc_pkg::OP_OUT : mmc_pkg::OP_NONE;
         default: ctrl.op = mmc_pkg::OP_NONE;
      endcase
   end

   mmc_lane u_lane_a (
      .clock (clock), .reset (reset), .ctrl (ctrl), .mask_in (mask_a_ff),
      .init_val (init_ff), .cap_gain (cap_gain_ff), .ind_gain (ind_gain_ff),
      .res_gain (res_gain_ff), .leak_gain (leak_ff), .vsrc_up (vsrc_up_ff),
      .vsrc_low (vsrc_low_ff), .vout (vout_a_ff), .head (head_a),
      .cur_up (up_a), .cur_low (low_a)
   );

   mmc_lane u_lane_b (
      .clock (clock), .reset (reset), .ctrl (ctrl), .mask_in (mask_b_ff),
      .init_val (init_ff), .cap_gain (cap_gain_ff), .ind_gain (ind_gain_ff),
      .res_gain (res_gain_ff), .leak_gain (leak_ff), .vsrc_up (vsrc_up_ff),
      .vsrc_low (vsrc_low_ff), .vout (vout_b_ff), .head (head_b),
      .cur_up (up_b), .cur_low (low_b)
   );

   mmc_lane u_lane_c (
      .clock (clock), .reset (reset), .ctrl (ctrl), .mask_in (mask_c_ff),
      .init_val (init_ff), .cap_gain (cap_gain_ff), .ind_gain (ind_gain_ff),
      .res_gain (res_gain_ff), .leak_gain (leak_ff), .vsrc_up (vsrc_up_ff),
      .vsrc_low (vsrc_low_ff), .vout (vout_c_ff), .head (head_c),
      .cur_up (up_c), .cur_low (low_c)
   );

   assign rsp_chan.valid          = (state_ff == ST_OUT);
   assign rsp_chan.cap_volt_a     = head_a;
   assign rsp_chan.cap_volt_b     = head_b;
   assign rsp_chan.cap_volt_c     = head_c;
   assign rsp_chan.cur_up_a       = up_a;
   assign rsp_chan.cur_low_a      = low_a;
   assign rsp_chan.cur_up_b       = up_b;
   assign rsp_chan.cur_low_b      = low_b;
   assign rsp_chan.cur_up_c       = up_c;
   assign rsp_chan.cur_low_c      = low_c;
   assign rsp_chan.dc_pos_current = dc_pos_ff;
   assign rsp_chan.dc_neg_current = dc_neg_ff;
   assign rsp_chan.last_cell      = (cnt_ff == LAST_IDX);

endmodule

// ===== tb/sv/tb_mmc_converter_euler_step.sv =====
// Testbench for the converter Euler step: drives time steps, predicts the twelve
// results of each step and compares every field of them.
// Depends on mmc_pkg, mmc_req_if, mmc_rsp_if and mmc_converter_euler_step.
`timescale 1ns / 100ps

module tb_mmc_converter_euler_step;

   typedef struct packed {
      logic signed [31:0] cva, cvb, cvc;
      logic signed [31:0] iua, ila, iub, ilb, iuc, ilc;
      logic signed [31:0] dcp, dcn;
      logic               last;
   } cell_result_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   mmc_req_if req_chan ();
   mmc_rsp_if rsp_chan ();

   mmc_converter_euler_step dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [31:0] m_cap_gain, m_ind_gain, m_res, m_leak;
   logic signed [31:0] m_init;
   logic signed [31:0] m_cells [3*mmc_pkg::CELLS_PER_PHASE];
   logic signed [31:0] m_currents [6];

   cell_result_type result_queue [$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  rsp_hold = 1'b0;
   bit  rsp_random_stall = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   // round to nearest with ties up, then clamp
   function automatic logic signed [31:0] scale_gain(input logic signed [31:0] v,
                                                     input logic [31:0] g,
                                                     input int frac);
      logic signed [63:0] p;
      p = 64'(v) * $signed({32'd0, g});
      p = p + (64'sd1 <<< (frac - 1));
      return clamp32(p >>> frac);
   endfunction

   function automatic void load_cells();
      logic signed [31:0] neg;
      neg = clamp32(-64'(m_init));
      for (int p = 0; p < 3; p++)
         for (int i = 0; i < mmc_pkg::CELLS_PER_PHASE; i++)
            m_cells[p*mmc_pkg::CELLS_PER_PHASE+i] =
               (i < mmc_pkg::CELLS_PER_ARM) ? m_init : neg;
      for (int i = 0; i < 6; i++) m_currents[i] = '0;
   endfunction

   function automatic void model_reset();
      m_cap_gain = 0;
      m_ind_gain = 0;
      m_res = 6554;
      m_leak = 32'd1073741824;
      m_init = 0;
      load_cells();
   endfunction

   function automatic void predict_step(input logic [11:0] sw [3],
                                        input logic signed [31:0] vup,
                                        input logic signed [31:0] vlo,
                                        input logic signed [31:0] vo [3],
                                        input logic rl);
      logic signed [63:0] dc_pos, dc_neg, sum, drive;
      logic signed [31:0] past, now, vsrc;
      cell_result_type r;
      int c;
      dc_pos = 0;
      dc_neg = 0;
      if (rl) load_cells();
      for (int p = 0; p < 3; p++) begin
         for (int arm = 0; arm < 2; arm++) begin
            past = m_currents[p*2+arm];
            sum = 0;
            for (int i = arm*mmc_pkg::CELLS_PER_ARM;
                 i < (arm+1)*mmc_pkg::CELLS_PER_ARM; i++) begin
               c = p*mmc_pkg::CELLS_PER_PHASE + i;
               if (sw[p][i]) begin
                  m_cells[c] = clamp32(64'(m_cells[c]) +
                                       64'(scale_gain(past, m_cap_gain, 30)));
                  sum += 64'(m_cells[c]);
               end else begin
                  m_cells[c] = scale_gain(m_cells[c], m_leak, 30);
               end
            end
            vsrc = arm ? vlo : vup;
            drive = 64'(vsrc) - 64'(clamp32(sum)) -
                    64'(scale_gain(past, m_res, 16)) - 64'(vo[p]);
            now = clamp32(64'(past) +
                          64'(scale_gain(clamp32(drive), m_ind_gain, 30)));
            m_currents[p*2+arm] = now;
            if (arm == 0) dc_pos += 64'(now);
            else dc_neg += 64'(now);
         end
      end
      for (int k = 0; k < mmc_pkg::CELLS_PER_PHASE; k++) begin
         r.cva = m_cells[k];
         r.cvb = m_cells[mmc_pkg::CELLS_PER_PHASE+k];
         r.cvc = m_cells[2*mmc_pkg::CELLS_PER_PHASE+k];
         r.iua = m_currents[0]; r.ila = m_currents[1];
         r.iub = m_currents[2]; r.ilb = m_currents[3];
         r.iuc = m_currents[4]; r.ilc = m_currents[5];
         r.dcp = clamp32(dc_pos);
         r.dcn = clamp32(-dc_neg);
         r.last = (k == mmc_pkg::CELLS_PER_PHASE-1);
         result_queue.push_back(r);
      end
   endfunction

   initial begin
      req_chan.valid = 1'b0;
      req_chan.switch_a = '0; req_chan.switch_b = '0; req_chan.switch_c = '0;
      req_chan.dc_upper_volt = '0; req_chan.dc_lower_volt = '0;
      req_chan.out_volt_a = '0; req_chan.out_volt_b = '0; req_chan.out_volt_c = '0;
      req_chan.reload = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   function automatic int random_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
      return $urandom_range(0, 3);
   endfunction

   // receiver: random stalls, plus an explicit hold-off
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = rsp_random_stall ? random_gap() : 0;
         if (rsp_hold || gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap > 0 ? gap : 1) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      cell_result_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.cap_volt_a, rsp_chan.cap_volt_b, rsp_chan.cap_volt_c,
                rsp_chan.cur_up_a, rsp_chan.cur_low_a, rsp_chan.cur_up_b,
                rsp_chan.cur_low_b, rsp_chan.cur_up_c, rsp_chan.cur_low_c,
                rsp_chan.dc_pos_current, rsp_chan.dc_neg_current,
                rsp_chan.last_cell};
         if (result_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %p", got);
         end else begin
            want = result_queue.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mmc_pkg::REG_CAP_STEP_GAIN: m_cap_gain = {1'b0, val[30:0]};
         mmc_pkg::REG_IND_STEP_GAIN: m_ind_gain = {1'b0, val[30:0]};
         mmc_pkg::REG_ARM_RES:       m_res = {1'b0, val[30:0]};
         mmc_pkg::REG_LEAK_FACTOR:   m_leak = {1'b0, val[30:0]};
         mmc_pkg::REG_INIT_VOLT:     m_init = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      while (result_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_step(input logic [11:0] sa, input logic [11:0] sb,
                            input logic [11:0] sc, input logic [31:0] vup,
                            input logic [31:0] vlo, input logic [31:0] va,
                            input logic [31:0] vb, input logic [31:0] vc,
                            input logic rl);
      logic [11:0] sw [3];
      logic signed [31:0] vo [3];
      sw = '{sa, sb, sc};
      vo = '{va, vb, vc};
      req_chan.valid <= 1'b1;
      req_chan.switch_a <= sa; req_chan.switch_b <= sb; req_chan.switch_c <= sc;
      req_chan.dc_upper_volt <= vup; req_chan.dc_lower_volt <= vlo;
      req_chan.out_volt_a <= va; req_chan.out_volt_b <= vb; req_chan.out_volt_c <= vc;
      req_chan.reload <= rl;
      do @(posedge clock); while (!req_chan.ready);
      predict_step(sw, vup, vlo, vo, rl);
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_volt();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom();
         default: return $signed($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
      endcase
   endfunction

   task automatic send_random(input int gap_max);
      int gap;
      gap = (gap_max > 0) ? random_gap() : 0;
      repeat (gap) @(posedge clock);
      send_step(12'($urandom()), 12'($urandom()), 12'($urandom()), rand_volt(),
                rand_volt(), rand_volt(), rand_volt(), rand_volt(),
                $urandom_range(0, 9) == 0);
   endtask

   task automatic test_directed();
      write_reg(mmc_pkg::REG_INIT_VOLT, 32'h8000_0000);   // negation saturates
      write_reg(3'd7, 32'hFFFF_FFFF);                      // unknown index is ignored
      send_step(12'hFFF, 12'h000, 12'hAAA, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      drain();
      write_reg(mmc_pkg::REG_CAP_STEP_GAIN, 32'h0010_0000);
      write_reg(mmc_pkg::REG_IND_STEP_GAIN, 32'h0100_0000);
      write_reg(mmc_pkg::REG_ARM_RES, 32'h0001_0000);
      write_reg(mmc_pkg::REG_LEAK_FACTOR, 32'h3FF0_0000);
      write_reg(mmc_pkg::REG_INIT_VOLT, 32'h0032_0000);    // takes effect on reload only
      send_step(12'h555, 12'hFFF, 12'h0F0, 32'h0064_0000, 32'hFF9C_0000,
                32'h0001_0000, 32'h0, 32'hFFFF_0000, 1'b0);
      send_step(12'h03F, 12'hFC0, 12'h000, 32'h0064_0000, 32'hFF9C_0000,
                32'h0, 32'h0, 32'h0, 1'b1);
      send_step(12'hFFF, 12'hFFF, 12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      drain();
      // gains at and beyond the top of their range
      write_reg(mmc_pkg::REG_CAP_STEP_GAIN, 32'hFFFF_FFFF);
      write_reg(mmc_pkg::REG_IND_STEP_GAIN, 32'h7FFF_FFFF);
      write_reg(mmc_pkg::REG_ARM_RES, 32'h7FFF_FFFF);
      write_reg(mmc_pkg::REG_LEAK_FACTOR, 32'hFFFF_FFFF);
      write_reg(mmc_pkg::REG_INIT_VOLT, 32'h7FFF_FFFF);
      for (int i = 0; i < 6; i++) send_random(1);
      drain();
      write_reg(mmc_pkg::REG_CAP_STEP_GAIN, 32'h0);
      write_reg(mmc_pkg::REG_IND_STEP_GAIN, 32'h0);
      write_reg(mmc_pkg::REG_ARM_RES, 32'h0);
      write_reg(mmc_pkg::REG_LEAK_FACTOR, 32'h0);
      write_reg(mmc_pkg::REG_INIT_VOLT, 32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++) send_random(0);
      drain();
   endtask

   task automatic test_backpressure();
      rsp_hold = 1'b1;
      fork
         begin
            repeat (150) @(posedge clock);
            rsp_hold = 1'b0;
         end
         for (int i = 0; i < 4; i++) send_random(0);
      join
      drain();
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(mmc_pkg::REG_CAP_STEP_GAIN, $urandom_range(0, 32'h0400_0000));
         write_reg(mmc_pkg::REG_IND_STEP_GAIN, $urandom_range(0, 32'h1000_0000));
         write_reg(mmc_pkg::REG_ARM_RES, $urandom_range(0, 32'h0010_0000));
         write_reg(mmc_pkg::REG_LEAK_FACTOR,
                   $urandom_range(32'h3000_0000, 32'h4000_0000));
         write_reg(mmc_pkg::REG_INIT_VOLT, rand_volt());
         rsp_random_stall = (phase != 2);
         for (int i = 0; i < 28; i++) send_random(phase != 1);
         drain();
      end
   endtask

   initial begin
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      if (mismatches == 0 && result_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
